### sv/fulfsm_pkg.sv
// Shared types, codes and helper functions for the firmware update lifecycle guard.
`timescale 1ns / 1ps
package fulfsm_pkg;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CANCELED = 2'd2;
  localparam logic [1:0] ST_AGAIN    = 2'd3;

  // Run result and reconciled result codes.
  localparam logic [1:0] RES_PENDING = 2'd0;
  localparam logic [1:0] RES_OK      = 2'd1;
  localparam logic [1:0] RES_FAIL    = 2'd2;

  // Entries in the queue between the front and back parts.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Event kinds as seen by the back part; EV_BAD stands for anything rejected
  // by classification (unknown kind, finish with an unusable code).
  typedef enum logic [4:0] {
    EV_CLEAR        = 5'd0,
    EV_RESTORE      = 5'd1,
    EV_CLAIM        = 5'd2,
    EV_DL_PENDING   = 5'd3,
    EV_DL_STARTED   = 5'd4,
    EV_DL_DONE      = 5'd5,
    EV_FAIL_HANDLER = 5'd6,
    EV_FAIL_OP      = 5'd7,
    EV_FINISH       = 5'd8,
    EV_QUEUE_RESULT = 5'd9,
    EV_CLAIM_COMPL  = 5'd10,
    EV_CLEAR_PROB   = 5'd11,
    EV_BEGIN_COMMIT = 5'd12,
    EV_CANCEL_COMMIT = 5'd13,
    EV_PREREBOOT    = 5'd14,
    EV_BEGIN_REBOOT = 5'd15,
    EV_UNCONFIRMED  = 5'd16,
    EV_SET_PAUSE    = 5'd17,
    EV_ABORT        = 5'd18,
    EV_BAD          = 5'd31
  } ev_kind_e;

  localparam logic [4:0] KIND_LAST = 5'd18;

  typedef enum logic [4:0] {
    UPG_IDLE     = 5'b00001,
    UPG_HANDLER  = 5'b00010,
    UPG_COMMIT   = 5'b00100,
    UPG_RB_READY = 5'b01000,
    UPG_RB_START = 5'b10000
  } upg_e;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_PEND_DL = 6'b000010,
    PH_DL      = 6'b000100,
    PH_PEND_UP = 6'b001000,
    PH_PEND_RB = 6'b010000,
    PH_UNCONF  = 6'b100000
  } phase_e;

  typedef enum logic [3:0] {
    PB_NONE    = 4'b0001,
    PB_PENDING = 4'b0010,
    PB_QUEUED  = 4'b0100,
    PB_CLAIMED = 4'b1000
  } prob_e;

  // One classified event as held in the queue.
  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  art_idx;
    logic        artifact_is_main;
    logic        owner_ok;
    logic        attempt_open;
    logic        pause_wanted;
    logic        cancel_req;
    logic [1:0]  result_code;
    logic        prob_wait;
  } ev_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic [2:0] phase;
    logic [1:0] run_result;
    logic       paused;
    logic [2:0] upgrade_stage;
    logic [1:0] probation_stage;
    logic       abort_seen;
    logic       consistent;
    logic       irreversible;
    logic       claim_ok;
    logic [7:0] held_index;
    logic [1:0] recon_res;
  } res_t;

  function automatic logic [2:0] upg_code(upg_e u);
    logic [2:0] c;
    case (u)
      UPG_IDLE:     c = 3'd0;
      UPG_HANDLER:  c = 3'd1;
      UPG_COMMIT:   c = 3'd2;
      UPG_RB_READY: c = 3'd3;
      UPG_RB_START: c = 3'd4;
      default:      c = 3'd7;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] phase_code(phase_e p);
    logic [2:0] c;
    case (p)
      PH_IDLE:    c = 3'd0;
      PH_PEND_DL: c = 3'd1;
      PH_DL:      c = 3'd2;
      PH_PEND_UP: c = 3'd3;
      PH_PEND_RB: c = 3'd4;
      PH_UNCONF:  c = 3'd5;
      default:    c = 3'd7;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] prob_code(prob_e p);
    logic [1:0] c;
    case (p)
      PB_NONE:    c = 2'd0;
      PB_PENDING: c = 2'd1;
      PB_QUEUED:  c = 2'd2;
      PB_CLAIMED: c = 2'd3;
      default:    c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic is_consistent(upg_e u, phase_e p, prob_e pb, logic [1:0] run);
    logic ok;
    logic mid;
    mid = (p == PH_PEND_DL) || (p == PH_DL) || (p == PH_PEND_UP) || (p == PH_PEND_RB);
    case (u)
      UPG_IDLE:     ok = !mid;
      UPG_HANDLER:  ok = (pb == PB_NONE) && (p != PH_PEND_RB) && (p != PH_UNCONF);
      UPG_COMMIT:   ok = (pb == PB_NONE) && (p == PH_PEND_UP);
      UPG_RB_READY,
      UPG_RB_START: ok = (pb == PB_PENDING) && (p == PH_PEND_RB);
      default:      ok = 1'b0;
    endcase
    if (((pb == PB_QUEUED) || (pb == PB_CLAIMED)) &&
        ((u != UPG_IDLE) || (p != PH_IDLE) || ((run != RES_OK) && (run != RES_FAIL)))) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### sv/firmware_update_lifecycle_fsm_core.sv
// Top level of the firmware update lifecycle guard: front, event queue and back.
//
//   Channel   Dir  Signals                     Moves
//   s_axis    in   tvalid tready tdata tuser   one event per transfer
//   m_axis    out  tvalid tready tdata         one result per event
//
// Throughput is one event per cycle while the back part's output register is
// empty or being drained. A result passes through the queue and then the output
// register before it can transfer on m_axis.
// The front classifies and pushes into a two-entry queue; the back pops when
// its output register is empty or being drained, so either side stalls alone.
// Reset clears the queue, the output valid and all lifecycle state.
`timescale 1ns / 1ps
module firmware_update_lifecycle_fsm_core #(
  parameter int unsigned INDEX_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] art_idx, [8] artifact_is_main, [9] owner_ok, [10] attempt_open,
  // [11] pause_wanted, [12] cancel_req, [14:13] result_code,
  // [15] prob_wait
  input  logic [15:0] s_axis_tdata,
  // [4:0] kind
  input  logic [4:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [4:2] phase, [6:5] run_result, [7] paused,
  // [10:8] upgrade_stage, [12:11] probation_stage, [13] abort_seen,
  // [14] consistent, [15] irreversible, [16] claim_ok, [24:17] held_index,
  // [26:25] recon_res, [31:27] zero
  output logic [31:0] m_axis_tdata
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  fulfsm_pkg::ev_t  ev_in;
  fulfsm_pkg::ev_t  ev_out;
  fulfsm_pkg::res_t res;

  fulfsm_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .kind_i    (s_axis_tuser),
    .data_i    (s_axis_tdata),
    .q_full_i  (q_full),
    .push_o    (push),
    .ev_o      (ev_in)
  );

  fulfsm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (ev_in),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (ev_out)
  );

  fulfsm_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .ev_i      (ev_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res)
  );

  assign m_axis_tdata = {5'd0, res.recon_res, res.held_index, res.claim_ok,
                         res.irreversible, res.consistent, res.abort_seen,
                         res.probation_stage, res.upgrade_stage, res.paused,
                         res.run_result, res.phase, res.status};

endmodule

### sv/fulfsm_front.sv
// Front part: takes input transfers and classifies each event for the back part.
`timescale 1ns / 1ps
module fulfsm_front (
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [4:0]       kind_i,
  input  logic [15:0]      data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output fulfsm_pkg::ev_t  ev_o
);

  logic [1:0] code;

  assign code      = data_i[14:13];
  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

  always_comb begin
    ev_o.art_idx          = data_i[7:0];
    ev_o.artifact_is_main = data_i[8];
    ev_o.owner_ok         = data_i[9];
    ev_o.attempt_open     = data_i[10];
    ev_o.pause_wanted     = data_i[11];
    ev_o.cancel_req       = data_i[12];
    ev_o.result_code      = code;
    ev_o.prob_wait        = data_i[15];
    // Unknown kinds and a finish with an unusable result code do nothing but
    // answer invalid, so both collapse into one kind here.
    if (kind_i > fulfsm_pkg::KIND_LAST) begin
      ev_o.kind = fulfsm_pkg::EV_BAD;
    end else if ((fulfsm_pkg::ev_kind_e'(kind_i) == fulfsm_pkg::EV_FINISH) &&
                 (code > fulfsm_pkg::RES_FAIL)) begin
      ev_o.kind = fulfsm_pkg::EV_BAD;
    end else begin
      ev_o.kind = fulfsm_pkg::ev_kind_e'(kind_i);
    end
  end

endmodule

### sv/fulfsm_queue.sv
// Short event queue that decouples the front and back parts.
`timescale 1ns / 1ps
module fulfsm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fulfsm_pkg::ev_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output fulfsm_pkg::ev_t  pop_data_o
);

  fulfsm_pkg::ev_t                       mem_q [fulfsm_pkg::QDepth];
  logic [fulfsm_pkg::QPtrW-1:0]          wr_ptr_q, wr_ptr_d;
  logic [fulfsm_pkg::QPtrW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [fulfsm_pkg::QCntW-1:0]          cnt_q, cnt_d;

  assign full_o     = (cnt_q == fulfsm_pkg::QCntW'(fulfsm_pkg::QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### sv/fulfsm_back.sv
// Back part: holds the lifecycle state, runs each event's guard and registers the result.
`timescale 1ns / 1ps
module fulfsm_back #(
  parameter int unsigned INDEX_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  fulfsm_pkg::ev_t  ev_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output fulfsm_pkg::res_t res_o
);

  // The event index is eight bits wide, so at most eight bits are ever held.
  localparam int unsigned IdxW = (INDEX_BITS < 8) ? INDEX_BITS : 8;

  logic                  present_q, present_d;
  fulfsm_pkg::upg_e      upg_q, upg_d;
  fulfsm_pkg::prob_e     prob_q, prob_d;
  fulfsm_pkg::phase_e    phase_q, phase_d;
  logic [1:0]            run_q, run_d;
  logic                  paused_q, paused_d;
  logic                  abort_q, abort_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic [1:0]            recon_q, recon_d;
  logic                  out_valid_q;
  fulfsm_pkg::res_t      res_q, res_d;

  logic [IdxW-1:0]       ev_idx;
  logic                  idx_match;
  logic                  can_pause;
  logic                  can_abort;
  logic [1:0]            st;
  logic                  claim;

  // A new event runs whenever the queue holds one and the output register is empty or being drained.
  assign pop_o     = !empty_i && (!out_valid_q || m_ready_i);
  assign m_valid_o = out_valid_q;
  assign res_o     = res_q;

  assign ev_idx    = ev_i.art_idx[IdxW-1:0];
  assign idx_match = (idx_q == ev_idx);
  assign can_pause = (phase_q == fulfsm_pkg::PH_PEND_DL) || (phase_q == fulfsm_pkg::PH_DL) ||
                     (phase_q == fulfsm_pkg::PH_PEND_UP) || (phase_q == fulfsm_pkg::PH_PEND_RB);
  assign can_abort = (phase_q == fulfsm_pkg::PH_PEND_DL) || (phase_q == fulfsm_pkg::PH_DL) ||
                     (phase_q == fulfsm_pkg::PH_PEND_UP);

  always_comb begin
    present_d = present_q;
    upg_d     = upg_q;
    prob_d    = prob_q;
    phase_d   = phase_q;
    run_d     = run_q;
    paused_d  = paused_q;
    abort_d   = abort_q;
    idx_d     = idx_q;
    recon_d   = recon_q;
    st        = fulfsm_pkg::ST_OK;
    claim     = 1'b0;

    case (ev_i.kind)
      fulfsm_pkg::EV_CLEAR, fulfsm_pkg::EV_RESTORE: begin
        present_d = 1'b0;
        upg_d     = fulfsm_pkg::UPG_IDLE;
        prob_d    = fulfsm_pkg::PB_NONE;
        phase_d   = fulfsm_pkg::PH_IDLE;
        run_d     = fulfsm_pkg::RES_PENDING;
        paused_d  = 1'b0;
        abort_d   = 1'b0;
        idx_d     = '0;
        recon_d   = fulfsm_pkg::RES_PENDING;
        if (ev_i.kind == fulfsm_pkg::EV_RESTORE) begin
          present_d = 1'b1;
          idx_d     = ev_idx;
          if (ev_i.prob_wait) begin
            prob_d = fulfsm_pkg::PB_PENDING;
          end
        end
      end
      fulfsm_pkg::EV_CLAIM: begin
        if (!ev_i.owner_ok || !ev_i.artifact_is_main || (upg_q != fulfsm_pkg::UPG_IDLE) ||
            (prob_q != fulfsm_pkg::PB_NONE)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          present_d = 1'b1;
          idx_d     = ev_idx;
          phase_d   = fulfsm_pkg::PH_IDLE;
          run_d     = fulfsm_pkg::RES_PENDING;
          paused_d  = 1'b0;
          abort_d   = 1'b0;
          upg_d     = fulfsm_pkg::UPG_HANDLER;
        end
      end
      fulfsm_pkg::EV_DL_PENDING: begin
        if (!ev_i.owner_ok || (upg_q != fulfsm_pkg::UPG_HANDLER) ||
            (phase_q != fulfsm_pkg::PH_IDLE)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          phase_d = fulfsm_pkg::PH_PEND_DL;
        end
      end
      fulfsm_pkg::EV_DL_STARTED: begin
        if (!ev_i.owner_ok || (phase_q != fulfsm_pkg::PH_PEND_DL)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          phase_d = fulfsm_pkg::PH_DL;
        end
      end
      fulfsm_pkg::EV_DL_DONE: begin
        if (!ev_i.owner_ok || (phase_q != fulfsm_pkg::PH_DL)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          phase_d = fulfsm_pkg::PH_PEND_UP;
        end
      end
      fulfsm_pkg::EV_FAIL_HANDLER, fulfsm_pkg::EV_FAIL_OP, fulfsm_pkg::EV_FINISH: begin
        if ((ev_i.kind == fulfsm_pkg::EV_FAIL_HANDLER) &&
            (!present_q ||
             ((upg_q != fulfsm_pkg::UPG_HANDLER) && (upg_q != fulfsm_pkg::UPG_COMMIT)) ||
             (prob_q != fulfsm_pkg::PB_NONE))) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          phase_d  = fulfsm_pkg::PH_IDLE;
          paused_d = 1'b0;
          abort_d  = 1'b0;
          upg_d    = fulfsm_pkg::UPG_IDLE;
          run_d    = (ev_i.kind == fulfsm_pkg::EV_FINISH) ? ev_i.result_code
                                                          : fulfsm_pkg::RES_FAIL;
        end
      end
      fulfsm_pkg::EV_QUEUE_RESULT: begin
        if (((ev_i.result_code != fulfsm_pkg::RES_OK) &&
             (ev_i.result_code != fulfsm_pkg::RES_FAIL)) ||
            (prob_q != fulfsm_pkg::PB_PENDING) || !present_q || !idx_match) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          phase_d  = fulfsm_pkg::PH_IDLE;
          paused_d = 1'b0;
          abort_d  = 1'b0;
          upg_d    = fulfsm_pkg::UPG_IDLE;
          run_d    = ev_i.result_code;
          recon_d  = ev_i.result_code;
          prob_d   = fulfsm_pkg::PB_QUEUED;
        end
      end
      fulfsm_pkg::EV_CLAIM_COMPL: begin
        if (prob_q != fulfsm_pkg::PB_QUEUED) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          prob_d = fulfsm_pkg::PB_CLAIMED;
          claim  = 1'b1;
        end
      end
      fulfsm_pkg::EV_CLEAR_PROB: begin
        if (!ev_i.owner_ok || (prob_q != fulfsm_pkg::PB_CLAIMED)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          prob_d = fulfsm_pkg::PB_NONE;
          upg_d  = fulfsm_pkg::UPG_IDLE;
        end
      end
      fulfsm_pkg::EV_BEGIN_COMMIT: begin
        if (!ev_i.owner_ok || (phase_q != fulfsm_pkg::PH_PEND_UP) ||
            (upg_q != fulfsm_pkg::UPG_HANDLER)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else if (abort_q || ev_i.cancel_req) begin
          st = fulfsm_pkg::ST_CANCELED;
        end else if (paused_q) begin
          st = fulfsm_pkg::ST_AGAIN;
        end else begin
          upg_d = fulfsm_pkg::UPG_COMMIT;
        end
      end
      fulfsm_pkg::EV_CANCEL_COMMIT: begin
        if ((upg_q != fulfsm_pkg::UPG_COMMIT) || (phase_q != fulfsm_pkg::PH_PEND_UP)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          upg_d = fulfsm_pkg::UPG_HANDLER;
        end
      end
      fulfsm_pkg::EV_PREREBOOT: begin
        if (!ev_i.owner_ok || (upg_q != fulfsm_pkg::UPG_COMMIT) ||
            (phase_q != fulfsm_pkg::PH_PEND_UP)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          prob_d  = fulfsm_pkg::PB_PENDING;
          upg_d   = fulfsm_pkg::UPG_RB_READY;
          phase_d = fulfsm_pkg::PH_PEND_RB;
          claim   = 1'b1;
        end
      end
      fulfsm_pkg::EV_BEGIN_REBOOT: begin
        if ((phase_q != fulfsm_pkg::PH_PEND_RB) || (upg_q != fulfsm_pkg::UPG_RB_READY) ||
            (prob_q != fulfsm_pkg::PB_PENDING)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else if (paused_q) begin
          st = fulfsm_pkg::ST_AGAIN;
        end else begin
          upg_d = fulfsm_pkg::UPG_RB_START;
        end
      end
      fulfsm_pkg::EV_UNCONFIRMED: begin
        if ((prob_q != fulfsm_pkg::PB_PENDING) || !present_q || !idx_match) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          phase_d  = fulfsm_pkg::PH_UNCONF;
          paused_d = 1'b0;
          run_d    = fulfsm_pkg::RES_PENDING;
          abort_d  = 1'b0;
          upg_d    = fulfsm_pkg::UPG_IDLE;
        end
      end
      fulfsm_pkg::EV_SET_PAUSE: begin
        if (!ev_i.attempt_open ||
            (ev_i.pause_wanted && (!can_pause || (upg_q == fulfsm_pkg::UPG_RB_START))) ||
            (!ev_i.pause_wanted && !paused_q)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          paused_d = ev_i.pause_wanted;
        end
      end
      fulfsm_pkg::EV_ABORT: begin
        if (!ev_i.attempt_open || !can_abort || (upg_q != fulfsm_pkg::UPG_HANDLER)) begin
          st = fulfsm_pkg::ST_INVALID;
        end else begin
          abort_d  = 1'b1;
          paused_d = 1'b0;
        end
      end
      default: begin
        st = fulfsm_pkg::ST_INVALID;
      end
    endcase

    res_d.status            = st;
    res_d.phase             = fulfsm_pkg::phase_code(phase_d);
    res_d.run_result        = run_d;
    res_d.paused            = paused_d;
    res_d.upgrade_stage     = fulfsm_pkg::upg_code(upg_d);
    res_d.probation_stage   = fulfsm_pkg::prob_code(prob_d);
    res_d.abort_seen        = ev_i.attempt_open && abort_d;
    res_d.consistent        = fulfsm_pkg::is_consistent(upg_d, phase_d, prob_d, run_d);
    res_d.irreversible      = (upg_d == fulfsm_pkg::UPG_COMMIT) ||
                              (upg_d == fulfsm_pkg::UPG_RB_READY) ||
                              (upg_d == fulfsm_pkg::UPG_RB_START);
    res_d.claim_ok          = claim;
    res_d.held_index        = 8'(idx_d);
    res_d.recon_res         = recon_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= 1'b0;
      upg_q       <= fulfsm_pkg::UPG_IDLE;
      prob_q      <= fulfsm_pkg::PB_NONE;
      phase_q     <= fulfsm_pkg::PH_IDLE;
      run_q       <= fulfsm_pkg::RES_PENDING;
      paused_q    <= 1'b0;
      abort_q     <= 1'b0;
      idx_q       <= '0;
      recon_q     <= fulfsm_pkg::RES_PENDING;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        present_q <= present_d;
        upg_q     <= upg_d;
        prob_q    <= prob_d;
        phase_q   <= phase_d;
        run_q     <= run_d;
        paused_q  <= paused_d;
        abort_q   <= abort_d;
        idx_q     <= idx_d;
        recon_q   <= recon_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
